[sv/lodi_pkg.sv]
// Shared types, constants and duration/odds tables for the link outage drop injector.
// No dependencies; every other file depends on this package.
package lodi_pkg;

    // Remainder and hold widths: largest divisor is 541, largest hold is 600
    localparam int DIV_W  = 10;
    localparam int HOLD_W = 10;
    localparam int LVL_W  = 2;

    // APB register file
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_IDX_OUTAGE = 1'b0;
    localparam logic REG_IDX_DROP   = 1'b1;

    localparam logic [LVL_W-1:0] LVL_OFF = 2'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture packet, seed both remainder units
        logic step;     // one remainder bit step
        logic finish;   // commit link state, load output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy; // output register full and not being taken
    } t_dp_status;

    // Lower bound of the hold time for the new link state
    function automatic logic [DIV_W-1:0] hold_low(input logic [LVL_W-1:0] level,
                                                  input logic to_up);
        logic [DIV_W-1:0] v;
        unique case (level)
            2'd1:    v = to_up ? 10'd60 : 10'd5;
            2'd2:    v = to_up ? 10'd10 : 10'd10;
            2'd3:    v = to_up ? 10'd5  : 10'd10;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Span (high - low + 1) of the hold time for the new link state
    function automatic logic [DIV_W-1:0] hold_span(input logic [LVL_W-1:0] level,
                                                   input logic to_up);
        logic [DIV_W-1:0] v;
        unique case (level)
            2'd1:    v = to_up ? 10'd541 : 10'd6;
            2'd2:    v = to_up ? 10'd51  : 10'd51;
            2'd3:    v = to_up ? 10'd6   : 10'd111;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

    // One-in-N drop odds
    function automatic logic [DIV_W-1:0] drop_odds(input logic [LVL_W-1:0] level);
        logic [DIV_W-1:0] v;
        unique case (level)
            2'd1:    v = 10'd500;
            2'd2:    v = 10'd100;
            2'd3:    v = 10'd50;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

endpackage

[sv/lodi_if.sv]
// Valid/ready channel interfaces for packets in and verdicts out.
// Depends on lodi_pkg for the hold width.
interface lodi_in_if #(
    parameter int TIME_WIDTH = 32,
    parameter int RAND_WIDTH = 31
) ();
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] now_seconds;
    logic [RAND_WIDTH-1:0] rand_interval;
    logic [RAND_WIDTH-1:0] rand_drop;

    modport source (output valid, now_seconds, rand_interval, rand_drop, input ready);
    modport sink   (input valid, now_seconds, rand_interval, rand_drop, output ready);
endinterface

interface lodi_out_if ();
    logic                        valid;
    logic                        ready;
    logic                        deliver;
    logic                        link_up;
    logic                        switched;
    logic [lodi_pkg::HOLD_W-1:0] hold_seconds;

    modport source (output valid, deliver, link_up, switched, hold_seconds, input ready);
    modport sink   (input valid, deliver, link_up, switched, hold_seconds, output ready);
endinterface

[sv/lodi_cfg.sv]
// APB register file: outage level and drop odds select.
// Depends on lodi_pkg.
module lodi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lodi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lodi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lodi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [lodi_pkg::LVL_W-1:0]       o_outage_level,
    output logic [lodi_pkg::LVL_W-1:0]       o_drop_sel
);
    import lodi_pkg::*;

    logic [LVL_W-1:0] r_outage_level, n_outage_level;
    logic [LVL_W-1:0] r_drop_sel, n_drop_sel;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write decode; byte-lane address bits are ignored
    always_comb begin
        n_outage_level = r_outage_level;
        n_drop_sel     = r_drop_sel;
        if (wr_en) begin
            unique case (paddr[REG_SEL_BIT])
                REG_IDX_OUTAGE: n_outage_level = pwdata[LVL_W-1:0];
                REG_IDX_DROP:   n_drop_sel     = pwdata[LVL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outage_level <= LVL_OFF;
            r_drop_sel     <= LVL_OFF;
        end else begin
            r_outage_level <= n_outage_level;
            r_drop_sel     <= n_drop_sel;
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (paddr[REG_SEL_BIT])
            REG_IDX_OUTAGE: prdata[LVL_W-1:0] = r_outage_level;
            REG_IDX_DROP:   prdata[LVL_W-1:0] = r_drop_sel;
        endcase
    end

    assign o_outage_level = r_outage_level;
    assign o_drop_sel     = r_drop_sel;

endmodule

[sv/lodi_rem.sv]
// Bit-serial restoring remainder unit: dividend mod a 10-bit divisor, one bit per step.
// Depends on lodi_pkg.
module lodi_rem #(
    parameter int DATA_W = 31
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [DATA_W-1:0]           i_dividend,
    input  logic [lodi_pkg::DIV_W-1:0]  i_divisor,
    input  logic                        i_step,
    output logic [lodi_pkg::DIV_W-1:0]  o_rem
);
    import lodi_pkg::*;

    logic [DATA_W-1:0] r_shift, n_shift;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // Bring in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_shift[DATA_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        if (i_load) begin
            n_shift = i_dividend;
            n_rem   = '0;
        end else if (i_step) begin
            n_shift = {r_shift[DATA_W-2:0], 1'b0};
            n_rem   = (trial >= {1'b0, r_div}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem   <= n_rem;
        if (i_load) begin
            r_div <= i_divisor;
        end
    end

    assign o_rem = r_rem;

endmodule

[sv/lodi_ctrl.sv]
// Sequencing state machine: accept, bit-serial remainder steps, commit.
// Depends on lodi_pkg.
module lodi_ctrl #(
    parameter int RAND_WIDTH = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output lodi_pkg::t_ctrl_cmd    o_cmd,
    input  lodi_pkg::t_dp_status   i_status
);
    import lodi_pkg::*;

    localparam int CNT_W = $clog2(RAND_WIDTH);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(RAND_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = i_in_valid && o_in_ready;
    assign o_cmd.step   = (r_state == S_DIV);
    assign o_cmd.finish = (r_state == S_DONE) && !i_status.out_busy;

    // Next state and bit counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_DIV;
                    n_cnt   = LAST_CNT;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Last remainder step always leads to the commit state
    a_div_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_DONE))
        else $error("remainder sequence did not end in commit state");

endmodule

[sv/lodi_dp.sv]
// Datapath: link state, switch time, two remainder units and the output register.
// Depends on lodi_pkg and lodi_rem.
module lodi_dp #(
    parameter int TIME_WIDTH = 32,
    parameter int RAND_WIDTH = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lodi_pkg::t_ctrl_cmd           i_cmd,
    output lodi_pkg::t_dp_status          o_status,
    input  logic [lodi_pkg::LVL_W-1:0]    i_outage_level,
    input  logic [lodi_pkg::LVL_W-1:0]    i_drop_sel,
    input  logic [TIME_WIDTH-1:0]         i_now,
    input  logic [RAND_WIDTH-1:0]         i_rand_interval,
    input  logic [RAND_WIDTH-1:0]         i_rand_drop,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_deliver,
    output logic                          o_link_up,
    output logic                          o_switched,
    output logic [lodi_pkg::HOLD_W-1:0]   o_hold
);
    import lodi_pkg::*;

    // Link state
    logic                  r_started, n_started;
    logic                  r_link_up, n_link_up;
    logic [TIME_WIDTH:0]   r_switch_time, n_switch_time;
    logic [TIME_WIDTH-1:0] r_now;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_deliver, r_out_link_up, r_switched;
    logic [HOLD_W-1:0]     r_hold;

    logic                  eff_up;
    logic [TIME_WIDTH:0]   eff_sw;
    logic [TIME_WIDTH:0]   now_ext;
    logic                  do_switch;
    logic [DIV_W-1:0]      rem_int, rem_drop;
    logic [HOLD_W-1:0]     hold_pick, hold;
    logic                  new_up;
    logic                  drop_hit;
    logic                  deliver;

    // The first packet behaves as if state were already running from now
    assign now_ext = {1'b0, r_now};
    assign eff_up  = r_started ? r_link_up : (i_outage_level == LVL_OFF);
    assign eff_sw  = r_started ? r_switch_time : now_ext;

    lodi_rem #(.DATA_W(RAND_WIDTH)) u_rem_int (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_dividend (i_rand_interval),
        .i_divisor  (hold_span(i_outage_level, !eff_up)),
        .i_step     (i_cmd.step),
        .o_rem      (rem_int)
    );

    lodi_rem #(.DATA_W(RAND_WIDTH)) u_rem_drop (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_dividend (i_rand_drop),
        .i_divisor  (drop_odds(i_drop_sel)),
        .i_step     (i_cmd.step),
        .o_rem      (rem_drop)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now;
        end
    end

    // Switch and drop decision
    assign do_switch = (i_outage_level != LVL_OFF) && (now_ext >= eff_sw);
    assign hold_pick = hold_low(i_outage_level, !eff_up) + rem_int;
    assign hold      = do_switch ? hold_pick : '0;
    assign new_up    = do_switch ? !eff_up : eff_up;
    assign drop_hit  = (i_drop_sel != LVL_OFF) && (rem_drop == '0);
    assign deliver   = new_up && !drop_hit;

    always_comb begin
        n_started     = r_started;
        n_link_up     = r_link_up;
        n_switch_time = r_switch_time;
        if (i_cmd.finish) begin
            n_started = 1'b1;
            n_link_up = new_up;
            if (do_switch) begin
                n_switch_time = now_ext + {{(TIME_WIDTH + 1 - HOLD_W){1'b0}}, hold};
            end else begin
                n_switch_time = eff_sw;
            end
        end
    end

    // Output valid: set on commit, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_link_up     <= 1'b0;
            r_switch_time <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_started     <= n_started;
            r_link_up     <= n_link_up;
            r_switch_time <= n_switch_time;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_deliver     <= deliver;
            r_out_link_up <= new_up;
            r_switched    <= do_switch;
            r_hold        <= hold;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_deliver         = r_deliver;
    assign o_link_up         = r_out_link_up;
    assign o_switched        = r_switched;
    assign o_hold            = r_hold;

    a_deliver_needs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_link_up || !r_deliver))
        else $error("packet delivered while link down");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_switched ? (r_hold >= 10'd5 && r_hold <= 10'd600)
                                    : (r_hold == '0)))
        else $error("hold time out of range");

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("schedule lost its started flag");

endmodule

[sv/link_outage_drop_injector_top.sv]
// Link outage and random drop injector: one verdict per packet.
// Channels: i_pkt (sink) carries now_seconds, rand_interval and rand_drop; o_res
// (source) carries deliver, link_up, switched and hold_seconds; both are valid/ready
// and a transfer happens when valid and ready are high at a rising edge.
// Configuration: APB port, outage level at byte 0x0, drop odds select at byte 0x4
// (byte-lane address bits ignored), pready tied high, no wait states.
// Sequence: after the packet transfer the two bit-serial remainder units (hold time
// and drop roll) step one dividend bit per cycle side by side; the verdict is then
// committed into the output register when the output register is free. A new packet
// is accepted only after that commit, not while the remainder steps are running.
// The next packet is taken while an earlier verdict still waits in the output
// register; if that verdict is still not taken when the next one is ready, the
// block holds in its commit state and i_pkt.ready stays low.
// Reset (i_rst_n low, synchronous): both levels go to 0, the link schedule is
// cleared and the first packet afterwards starts it again.
// Depends on lodi_pkg, lodi_if, lodi_cfg, lodi_ctrl, lodi_dp.
module link_outage_drop_injector_top #(
    parameter int TIME_WIDTH = 32,
    parameter int RAND_WIDTH = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lodi_in_if.sink                          i_pkt,
    lodi_out_if.source                       o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lodi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lodi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lodi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import lodi_pkg::*;

    logic [LVL_W-1:0] outage_level;
    logic [LVL_W-1:0] drop_sel;
    t_ctrl_cmd        cmd;
    t_dp_status       status;

    lodi_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_outage_level (outage_level),
        .o_drop_sel     (drop_sel)
    );

    lodi_ctrl #(.RAND_WIDTH(RAND_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .o_in_ready (i_pkt.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    lodi_dp #(.TIME_WIDTH(TIME_WIDTH), .RAND_WIDTH(RAND_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_outage_level  (outage_level),
        .i_drop_sel      (drop_sel),
        .i_now           (i_pkt.now_seconds),
        .i_rand_interval (i_pkt.rand_interval),
        .i_rand_drop     (i_pkt.rand_drop),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_deliver       (o_res.deliver),
        .o_link_up       (o_res.link_up),
        .o_switched      (o_res.switched),
        .o_hold          (o_res.hold_seconds)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for link_outage_drop_injector_top: drives packets and APB writes,
// predicts each verdict in a scoreboard class and checks results in order.
// Depends on lodi_pkg, lodi_if and the RTL top level.
module tb;
    import lodi_pkg::*;

    localparam int TIME_W = 32;
    localparam int RAND_W = 31;

    // One verdict as seen on the result channel
    typedef struct packed {
        logic              deliver;
        logic              link_up;
        logic              switched;
        logic [HOLD_W-1:0] hold;
    } t_verdict;

    // Link schedule predictor and queue of verdicts still to arrive
    class t_verdict_scoreboard;
        bit [1:0]  outage_lvl;
        bit [1:0]  drop_lvl;
        bit        started;
        bit        link_up;
        bit [32:0] switch_at;
        t_verdict  expected_q[$];
        int        n_fail;

        task report(string msg);
            n_fail++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Hold time for the state being entered: low + r mod span
        function bit [HOLD_W-1:0] pick_hold(bit [1:0] lvl, bit to_up, bit [RAND_W-1:0] r);
            int unsigned lo;
            int unsigned hi;
            case (lvl)
                2'd1: begin
                    lo = to_up ? 60 : 5;
                    hi = to_up ? 600 : 10;
                end
                2'd2: begin
                    lo = 10;
                    hi = 60;
                end
                default: begin
                    lo = to_up ? 5 : 10;
                    hi = to_up ? 10 : 120;
                end
            endcase
            return HOLD_W'(lo + r % (hi - lo + 1));
        endfunction

        function int unsigned drop_odds_for(bit [1:0] lvl);
            case (lvl)
                2'd1:    return 500;
                2'd2:    return 100;
                default: return 50;
            endcase
        endfunction

        // Accepted packet: advance the schedule and queue its verdict
        function void note_packet(bit [TIME_W-1:0] now, bit [RAND_W-1:0] r_int,
                                  bit [RAND_W-1:0] r_drop);
            t_verdict v;
            v = '0;
            if (!started) begin
                started   = 1'b1;
                link_up   = (outage_lvl == LVL_OFF);
                switch_at = {1'b0, now};
            end
            if (outage_lvl != LVL_OFF && {1'b0, now} >= switch_at) begin
                v.hold     = pick_hold(outage_lvl, !link_up, r_int);
                link_up    = !link_up;
                v.switched = 1'b1;
                switch_at  = {1'b0, now} + 33'(v.hold);
            end
            v.link_up = link_up;
            v.deliver = link_up;
            // drop roll only while the link is up
            if (drop_lvl != LVL_OFF && link_up && (r_drop % drop_odds_for(drop_lvl)) == 0)
                v.deliver = 1'b0;
            expected_q.push_back(v);
        endfunction

        task check_result(t_verdict got);
            t_verdict e;
            if (expected_q.size() == 0) begin
                report("verdict with nothing outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (got.deliver !== e.deliver)
                report($sformatf("deliver %b, want %b", got.deliver, e.deliver));
            if (got.link_up !== e.link_up)
                report($sformatf("link_up %b, want %b", got.link_up, e.link_up));
            if (got.switched !== e.switched)
                report($sformatf("switched %b, want %b", got.switched, e.switched));
            if (got.hold !== e.hold)
                report($sformatf("hold_seconds %0d, want %0d", got.hold, e.hold));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lodi_in_if #(.TIME_WIDTH(TIME_W), .RAND_WIDTH(RAND_W)) pkt_ch ();
    lodi_out_if res_ch ();

    link_outage_drop_injector_top #(
        .TIME_WIDTH(TIME_W),
        .RAND_WIDTH(RAND_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_verdict_scoreboard sb;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  holdoff_left;
    bit [TIME_W-1:0]     t_now;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Run limit
    initial begin
        #12_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check each transfer, then pick next ready
    initial begin
        t_verdict got;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                got.deliver  = res_ch.deliver;
                got.link_up  = res_ch.link_up;
                got.switched = res_ch.switched;
                got.hold     = res_ch.hold_seconds;
                sb.check_result(got);
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one packet, with random idle cycles first; returns at its transfer
    task send_packet(bit [TIME_W-1:0] now, bit [RAND_W-1:0] r_int, bit [RAND_W-1:0] r_drop);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pkt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_ch.valid         <= 1'b1;
        pkt_ch.now_seconds   <= now;
        pkt_ch.rand_interval <= r_int;
        pkt_ch.rand_drop     <= r_drop;
        do @(posedge i_clk); while (!pkt_ch.ready);
        sb.note_packet(now, r_int, r_drop);
    endtask

    // Mostly small forward steps, some jumps, a few steps back
    task send_random();
        int unsigned r;
        bit [31:0]   ri;
        bit [31:0]   rd;
        r = $urandom_range(0, 99);
        if (r < 70)
            t_now += $urandom_range(0, 15);
        else if (r < 85)
            t_now += $urandom_range(16, 200);
        else if (r < 95) begin
            if (t_now > 30)
                t_now -= $urandom_range(1, 30);
        end else
            t_now += $urandom_range(201, 2000);
        ri = $urandom;
        rd = $urandom;
        r  = $urandom_range(0, 99);
        // bias the drop word toward multiples of the odds
        if (r < 8)
            rd = $urandom_range(0, 4294967) * 500;
        else if (r < 16)
            rd = $urandom_range(0, 42949672) * 50;
        send_packet(t_now, ri[RAND_W-1:0], rd[RAND_W-1:0]);
    endtask

    // Release the input and wait until every verdict has come back
    task drain();
        pkt_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register
    task cfg_write(logic idx, bit [1:0] val);
        logic [APB_ADDR_W-1:0] addr;
        addr              = '0;
        addr[REG_SEL_BIT] = idx;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_IDX_OUTAGE)
            sb.outage_lvl = val;
        else
            sb.drop_lvl = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(val))
            sb.report($sformatf("reg %0d reads %h, want %h", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task set_levels(bit [1:0] outage, bit [1:0] drop);
        cfg_write(REG_IDX_OUTAGE, outage);
        cfg_write(REG_IDX_DROP, drop);
    endtask

    task run_phase(bit [1:0] outage, bit [1:0] drop, int idle_pct, int stall_pct,
                   int holdoff, int count);
        set_levels(outage, drop);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        holdoff_left   = holdoff;
        t_now += $urandom_range(0, 1 << 27);
        repeat (count) send_random();
        drain();
    endtask

    // Main sequence
    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        t_now          = 32'd2000;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        pkt_ch.valid         <= 1'b0;
        pkt_ch.now_seconds   <= '0;
        pkt_ch.rand_interval <= '0;
        pkt_ch.rand_drop     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset levels: first packet brings the link up, time extremes and a step back
        send_packet(32'd0, 31'd0, 31'd0);
        send_packet(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_packet(32'd5, 31'd12345, 31'd0);
        drain();

        // Outages turned on later: stored switch time is already due
        set_levels(2'd1, 2'd1);
        send_packet(32'd10, 31'h7FFF_FFFF, 31'd7);
        send_packet(32'd12, 31'd3, 31'd0);          // down: no drop roll
        send_packet(32'd16, 31'd0, 31'd1);
        send_packet(32'd20, 31'd99, 31'd0);         // up and rolled a drop
        send_packet(32'd20, 31'd99, 31'd500);
        send_packet(32'd8, 31'd1, 31'd2);           // time went back
        drain();

        set_levels(2'd3, 2'd3);
        send_packet(32'd76, 31'd110, 31'd50);
        send_packet(32'd196, 31'd5, 31'd50);
        send_packet(32'd200, 31'd5, 31'h7FFF_FFFF);
        drain();

        set_levels(2'd2, 2'd2);
        send_packet(32'd206, 31'd50, 31'd100);
        send_packet(32'd300, 31'd77, 31'd100);
        send_packet(32'd400, 31'd1, 31'd3);
        drain();

        // Outages turned off while the link is down: it stays down
        set_levels(2'd0, 2'd3);
        send_packet(32'd1000, 31'd4, 31'd0);
        send_packet(32'd1500, 31'd9, 31'd50);
        drain();

        // Random phases over the idling modes, with two long receiver hold-offs
        run_phase(2'd1, 2'd1, 0, 0, 400, 110);
        run_phase(2'd2, 2'd2, 87, 0, 0, 110);
        run_phase(2'd3, 2'd3, 0, 87, 0, 110);
        run_phase(2'd3, 2'd0, 32, 32, 0, 110);
        run_phase(2'd0, 2'd2, 0, 0, 300, 100);
        run_phase(2'd2, 2'd3, 87, 0, 0, 110);
        run_phase(2'd1, 2'd0, 0, 87, 0, 110);
        run_phase(2'd3, 2'd1, 32, 32, 0, 100);

        // Near the top of the time range: next switch time runs past 32 bits
        set_levels(2'd3, 2'd3);
        for (int i = 0; i < 16; i++)
            send_packet(32'hFFFF_FF00 + 32'(i * 17), 31'($urandom), 31'($urandom));
        send_packet(32'hFFFF_FFFF, 31'd110, 31'($urandom));
        drain();

        repeat (50) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.expected_q.size()));
        if (sb.n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
